// ----- hdl/crp_pkg.sv -----
package crp_pkg;

  // sequencer states
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_CHECK = 7'b0000010,
    ST_MUL   = 7'b0000100,
    ST_ACC   = 7'b0001000,
    ST_FOLD  = 7'b0010000,
    ST_DONE  = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  // fold step codes
  typedef enum logic [1:0] {
    FOLD_C0  = 2'd0,
    FOLD_T   = 2'd1,
    FOLD_C1  = 2'd2,
    FOLD_C2  = 2'd3
  } fold_t;

endpackage

// ----- hdl/crp_mul.sv -----
// signed multiply with overflow flag, over four half-width partial products
module crp_mul #(
  parameter int W = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [W-1:0] a,
  input  logic signed [W-1:0] b,
  output logic signed [W-1:0] prod,
  output logic                ovf,
  output logic                done
);

  localparam int H  = (W + 1) / 2;
  localparam int HW = 2 * H;
  localparam int PW = 4 * H;

  logic [HW-1:0] am, bm;
  logic          neg;
  logic [PW-1:0] mag;
  logic [1:0]    cnt;
  logic          busy;

  logic [W-1:0]  abs_a, abs_b;
  logic [H-1:0]  pa, pb;
  logic [HW-1:0] pp;
  logic [PW-1:0] pp_shift;

  // operand magnitudes and the current partial product
  always_comb begin
    abs_a = a[W-1] ? -a : a;
    abs_b = b[W-1] ? -b : b;
    pa    = cnt[1] ? am[HW-1:H] : am[H-1:0];
    pb    = cnt[0] ? bm[HW-1:H] : bm[H-1:0];
    pp    = pa * pb;
    case (cnt)
      2'd0:    pp_shift = PW'(pp);
      2'd3:    pp_shift = PW'(pp) << HW;
      default: pp_shift = PW'(pp) << H;
    endcase
  end

  // signed result and range check of the exact magnitude
  always_comb begin
    prod = neg ? -mag[W-1:0] : mag[W-1:0];
    if (neg) begin
      ovf = (|mag[PW-1:W]) || (mag[W-1] && (|mag[W-2:0]));
    end else begin
      ovf = (|mag[PW-1:W]) || mag[W-1];
    end
  end

  // load, then one partial product per cycle; done for one cycle after
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == 2'd3);
      if (busy) begin
        mag <= mag + pp_shift;
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) busy <= 1'b0;
      end else if (start && !done) begin
        am   <= HW'(abs_a);
        bm   <= HW'(abs_b);
        neg  <= a[W-1] ^ b[W-1];
        mag  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end
    end
  end

endmodule

// ----- hdl/cubic_ring_power_top.sv -----
// channel | dir | tdata fields (lsb up)                       | tuser
// s_axis  | in  | exponent[31:0]                              | -
// m_axis  | out | coeff_zero, coeff_one, coeff_two (64 each)  | status
// one ring product is a check step, 9 multiply rounds (operand load,
// 4 partial products, done, accumulate) and 4 fold steps; an item takes
// up to 2*EXP_WIDTH-1 products, but with 64-bit coefficients the first
// overflow ends any exponent within about 17 products; exponent zero goes
// from the check step straight to done.
// s_axis_tready is high only in idle; the result holds until m_axis_tready.
// reset is synchronous and returns the sequencer to idle.
module cubic_ring_power_top
  import crp_pkg::*;
#(
  parameter int COEFF_WIDTH = 64,
  parameter int EXP_WIDTH   = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,   // exponent
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [191:0] m_axis_tdata,   // coeff_zero, coeff_one, coeff_two
  output logic         m_axis_tuser    // status
);

  localparam int W = COEFF_WIDTH;

  state_t state;
  logic [EXP_WIDTH-1:0] e;
  logic signed [W-1:0] acc [3];
  logic signed [W-1:0] fac [3];
  logic signed [W-1:0] k [5];
  logic signed [W-1:0] tsum;
  logic [1:0] ii, jj;
  logic       sq;       // current product is the factor squared
  fold_t      fstep;
  logic       bad;

  logic signed [W-1:0] ma, mb, prod;
  logic                movf;
  logic                mul_start;
  logic                mul_done;

  // multiplier operands
  always_comb begin
    ma = sq ? fac[ii] : acc[ii];
    mb = fac[jj];
  end

  assign mul_start = (state == ST_MUL);

  crp_mul #(.W(W)) u_mul (
    .clk  (clk),
    .rst  (rst),
    .start(mul_start),
    .a    (ma),
    .b    (mb),
    .prod (prod),
    .ovf  (movf),
    .done (mul_done)
  );

  // shared adder with overflow check
  logic signed [W-1:0] ad_a, ad_b, ad_s;
  logic                ad_ovf;
  logic [2:0]          kidx;
  always_comb begin
    kidx = 3'(ii) + 3'(jj);
    ad_a = k[kidx];
    ad_b = prod;
    case (fstep)
      FOLD_C0: if (state == ST_FOLD) begin ad_a = k[0]; ad_b = k[3]; end
      FOLD_T:  if (state == ST_FOLD) begin ad_a = k[1]; ad_b = k[3]; end
      FOLD_C1: if (state == ST_FOLD) begin ad_a = tsum; ad_b = k[4]; end
      FOLD_C2: if (state == ST_FOLD) begin ad_a = k[2]; ad_b = k[4]; end
      default: ;
    endcase
    ad_s   = ad_a + ad_b;
    ad_ovf = (ad_a[W-1] == ad_b[W-1]) && (ad_s[W-1] != ad_a[W-1]);
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = (state == ST_OUT);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: if (s_axis_tvalid) begin
          e <= s_axis_tdata[EXP_WIDTH-1:0];
          acc[0] <= W'(1); acc[1] <= '0; acc[2] <= '0;
          fac[0] <= '0; fac[1] <= W'(1); fac[2] <= '0;
          bad <= 1'b0;
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          for (int n = 0; n < 5; n++) k[n] <= '0;
          ii <= '0; jj <= '0; fstep <= FOLD_C0;
          if (e == '0) state <= ST_DONE;
          else if (e[0]) begin sq <= 1'b0; state <= ST_MUL; end
          else if ((e >> 1) != '0) begin sq <= 1'b1; e <= e >> 1; state <= ST_MUL; end
          else state <= ST_DONE;
        end
        ST_MUL: if (mul_done) state <= ST_ACC;
        ST_ACC: begin
          if (movf || ad_ovf) begin
            bad <= 1'b1; state <= ST_DONE;
          end else begin
            k[kidx] <= ad_s;
            if (jj == 2'd2) begin
              jj <= '0;
              if (ii == 2'd2) state <= ST_FOLD;
              else begin ii <= ii + 2'd1; state <= ST_MUL; end
            end else begin
              jj <= jj + 2'd1; state <= ST_MUL;
            end
          end
        end
        ST_FOLD: begin
          ii <= '0; jj <= '0;
          if (ad_ovf) begin
            bad <= 1'b1; state <= ST_DONE;
          end else begin
            case (fstep)
              FOLD_C0: begin k[0] <= ad_s; fstep <= FOLD_T; end
              FOLD_T:  begin tsum <= ad_s; fstep <= FOLD_C1; end
              FOLD_C1: begin k[1] <= ad_s; fstep <= FOLD_C2; end
              default: begin
                if (sq) begin
                  fac[0] <= k[0]; fac[1] <= k[1]; fac[2] <= ad_s;
                end else begin
                  acc[0] <= k[0]; acc[1] <= k[1]; acc[2] <= ad_s;
                  // clear the bit just used so the square step follows
                  e[0] <= 1'b0;
                end
                state <= ST_CHECK;
              end
            endcase
          end
        end
        ST_DONE: state <= ST_OUT;
        ST_OUT: if (m_axis_tready) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result payload, sign extended to 64 bits; all zero when status flags overflow
  always_comb begin
    if (bad) begin
      m_axis_tdata = '0;
    end else begin
      m_axis_tdata = {64'(acc[2]), 64'(acc[1]), 64'(acc[0])};
    end
    m_axis_tuser = bad;
  end

endmodule
